>>> rtl/wfb_pkg.sv
// ----------------------------------------------------------------------------
// wfb_pkg
// Shared types and constants of the weighted frame blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wfb_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int WEIGHT_BITS = 16;
    localparam int SUM_BITS    = 32;
    localparam int CFG_DATA_W  = 13;
    localparam int FE_REG_W    = 13;
    localparam int FC_REG_W    = 5;
    localparam int FE_RESET    = 4096;
    localparam int FC_RESET    = 1;

    typedef enum logic [0:0] {
        CFG_FRAME_ELEMENTS = 1'b0,
        CFG_FRAME_COUNT    = 1'b1
    } wfb_cfg_idx_t;

    typedef struct packed {
        logic                valid;
        logic                last_elem;
        logic [SUM_BITS-1:0] sum;
        logic [SUM_BITS-1:0] total;
    } wfb_acc_t;

    typedef struct packed {
        logic                   valid;
        logic                   last_elem;
        logic                   zero;
        logic [SAMPLE_BITS-1:0] blended;
    } wfb_res_t;

endpackage

`default_nettype wire

>>> rtl/wfb_accum.sv
// ----------------------------------------------------------------------------
// wfb_accum
// Sequencing, weight total and per-element accumulator store.
// ----------------------------------------------------------------------------
`default_nettype none

module wfb_accum import wfb_pkg::*; #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int MAX_FRAMES   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    input  wire logic signed [WEIGHT_BITS-1:0] weight,
    input  wire logic                          cfg_write,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    output wfb_acc_t                           acc
);

    localparam int EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int EC = $clog2(MAX_ELEMENTS + 1);
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FC = $clog2(MAX_FRAMES + 1);

    logic [EW-1:0]       elem_reg;
    logic [FW-1:0]       frame_reg;
    logic [SUM_BITS-1:0] total_reg;
    logic [EC-1:0]       fe_reg;
    logic [FC-1:0]       fc_reg;

    logic [SUM_BITS-1:0] mem [MAX_ELEMENTS];

    logic                a_valid_reg;
    logic [EW-1:0]       a_addr_reg;
    logic [SUM_BITS-1:0] a_prod_reg;
    logic                a_first_reg;
    logic                a_emit_reg;
    logic                a_last_reg;
    logic [SUM_BITS-1:0] a_total_reg;
    logic                a_fwd_reg;
    logic [SUM_BITS-1:0] rd_reg;

    logic                b_valid_reg;
    logic                b_last_reg;
    logic [SUM_BITS-1:0] b_sum_reg;
    logic [SUM_BITS-1:0] b_total_reg;

    logic                accept;
    logic                last_elem;
    logic                last_frame;
    logic                first_frame;
    logic [SUM_BITS-1:0] weight_ext;
    logic [SUM_BITS-1:0] total_next;
    logic [SUM_BITS-1:0] prod;
    logic [SUM_BITS-1:0] base;
    logic [SUM_BITS-1:0] sum_next;
    logic [EC-1:0]       fe_clamped;
    logic [FC-1:0]       fc_clamped;

    assign accept      = in_valid && en;
    assign last_elem   = ((EC'(elem_reg) + EC'(1)) >= fe_reg);
    assign last_frame  = ((FC'(frame_reg) + FC'(1)) >= fc_reg);
    assign first_frame = (frame_reg == '0);
    assign weight_ext  = SUM_BITS'(weight);

    always_comb
    begin
        total_next = total_reg;
        if (elem_reg == '0)
        begin
            total_next = first_frame ? weight_ext : total_reg + weight_ext;
        end
    end

    assign prod = SUM_BITS'($signed(weight) * $signed({1'b0, sample}));

    always_comb
    begin
        if (cfg_data == '0)
        begin
            fe_clamped = EC'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_ELEMENTS))
        begin
            fe_clamped = EC'(MAX_ELEMENTS);
        end
        else
        begin
            fe_clamped = EC'(cfg_data);
        end
        if (cfg_data[FC_REG_W-1:0] == '0)
        begin
            fc_clamped = FC'(1);
        end
        else if (32'(cfg_data[FC_REG_W-1:0]) > 32'(MAX_FRAMES))
        begin
            fc_clamped = FC'(MAX_FRAMES);
        end
        else
        begin
            fc_clamped = FC'(cfg_data[FC_REG_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_reg  <= '0;
            frame_reg <= '0;
            total_reg <= '0;
            fe_reg    <= EC'((FE_RESET > MAX_ELEMENTS) ? MAX_ELEMENTS : FE_RESET);
            fc_reg    <= FC'((FC_RESET > MAX_FRAMES) ? MAX_FRAMES : FC_RESET);
        end
        else if (cfg_write)
        begin
            elem_reg  <= '0;
            frame_reg <= '0;
            total_reg <= '0;
            if (wfb_cfg_idx_t'(cfg_index) == CFG_FRAME_ELEMENTS)
            begin
                fe_reg <= fe_clamped;
            end
            else
            begin
                fc_reg <= fc_clamped;
            end
        end
        else if (accept)
        begin
            total_reg <= total_next;
            if (last_elem)
            begin
                elem_reg  <= '0;
                frame_reg <= last_frame ? '0 : frame_reg + FW'(1);
            end
            else
            begin
                elem_reg <= elem_reg + EW'(1);
            end
        end
    end

    assign base     = a_fwd_reg ? b_sum_reg : rd_reg;
    assign sum_next = a_first_reg ? a_prod_reg : base + a_prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_reg <= mem[elem_reg];
            if (a_valid_reg)
            begin
                mem[a_addr_reg] <= sum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg && a_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_addr_reg  <= elem_reg;
            a_prod_reg  <= prod;
            a_first_reg <= first_frame;
            a_emit_reg  <= last_frame;
            a_last_reg  <= last_elem;
            a_total_reg <= total_next;
            a_fwd_reg   <= a_valid_reg && (a_addr_reg == elem_reg);
            b_last_reg  <= a_last_reg;
            b_sum_reg   <= sum_next;
            b_total_reg <= a_total_reg;
        end
    end

    assign acc.valid     = b_valid_reg;
    assign acc.last_elem = b_last_reg;
    assign acc.sum       = b_sum_reg;
    assign acc.total     = b_total_reg;

endmodule

`default_nettype wire

>>> rtl/wfb_div.sv
// ----------------------------------------------------------------------------
// wfb_div
// Pipelined signed divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module wfb_div import wfb_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wfb_acc_t  acc,
    output wfb_res_t  res
);

    localparam int N = SUM_BITS;

    logic [0:N]   v_reg;
    logic [N-1:0] rem_reg [0:N];
    logic [N-1:0] nq_reg  [0:N];
    logic [N-1:0] den_reg [0:N];
    logic [0:N]   neg_reg;
    logic [0:N]   zero_reg;
    logic [0:N]   last_reg;

    logic [N-1:0] num_abs;
    logic [N-1:0] den_abs;
    logic [N-1:0] q_signed;

    assign num_abs = acc.sum[N-1] ? N'(-acc.sum) : acc.sum;
    assign den_abs = acc.total[N-1] ? N'(-acc.total) : acc.total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {acc.valid, v_reg[0:N-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            nq_reg[0]   <= num_abs;
            den_reg[0]  <= den_abs;
            neg_reg[0]  <= acc.sum[N-1] ^ acc.total[N-1];
            zero_reg[0] <= (acc.total == '0);
            last_reg[0] <= acc.last_elem;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [N:0]   trial;
        logic         ge;
        logic [N:0]   diff;

        assign trial = {rem_reg[k], nq_reg[k][N-1]};
        assign ge    = (trial >= {1'b0, den_reg[k]});
        assign diff  = trial - {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? diff[N-1:0] : trial[N-1:0];
                nq_reg[k+1]   <= {nq_reg[k][N-2:0], ge};
                den_reg[k+1]  <= den_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                last_reg[k+1] <= last_reg[k];
            end
        end
    end

    assign q_signed = neg_reg[N] ? N'(-nq_reg[N]) : nq_reg[N];

    assign res.valid     = v_reg[N];
    assign res.last_elem = last_reg[N];
    assign res.zero      = zero_reg[N];
    assign res.blended   = zero_reg[N] ? '0 : q_signed[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

>>> rtl/weighted_frame_blend_unit.sv
// ----------------------------------------------------------------------------
// weighted_frame_blend_unit
// Weighted mean of a group of frames, one element per clock while not stalled.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while in_ready is high and gives one
// blended element per clock while out_ready is high for each element of the
// last frame of a group, through the accumulator read, add and output stages
// and the 32 one-bit stages of the divider. Configuration writes restart the
// group; the user must make them only while the unit is idle (not enforced).
`default_nettype none

module weighted_frame_blend_unit import wfb_pkg::*; #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int MAX_FRAMES   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output wire logic                          in_ready,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    input  wire logic signed [WEIGHT_BITS-1:0] weight,
    output wire logic                          out_valid,
    input  wire logic                          out_ready,
    output wire logic [SAMPLE_BITS-1:0]        blended,
    output wire logic                          frame_end,
    output wire logic                          zero_weight,
    input  wire logic                          cfg_write,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

    wfb_acc_t acc;
    wfb_res_t res;
    wfb_res_t out_reg;
    wfb_res_t skid_reg;
    logic     en;

    assign en       = !skid_reg.valid;
    assign in_ready = en;

    wfb_accum #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .MAX_FRAMES  (MAX_FRAMES)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .sample   (sample),
        .weight   (weight),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .acc      (acc)
    );

    wfb_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .acc  (acc),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else if (out_reg.valid && out_ready)
        begin
            if (skid_reg.valid)
            begin
                out_reg        <= skid_reg;
                skid_reg.valid <= 1'b0;
            end
            else if (res.valid)
            begin
                out_reg <= res;
            end
            else
            begin
                out_reg.valid <= 1'b0;
            end
        end
        else if (en && res.valid)
        begin
            if (!out_reg.valid)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign out_valid   = out_reg.valid;
    assign blended     = out_reg.blended;
    assign frame_end   = out_reg.last_elem;
    assign zero_weight = out_reg.zero;

endmodule

`default_nettype wire

>>> rtl/wfb_checker.sv
// ----------------------------------------------------------------------------
// wfb_checker
// Port-level checks of the weighted frame blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

module wfb_checker import wfb_pkg::*; (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [SAMPLE_BITS-1:0]        blended,
    input wire logic                          frame_end,
    input wire logic                          zero_weight
);

    a_zero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_weight |-> blended == '0)
        else $error("zero total weight with nonzero result");

    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled while no result is waiting");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(blended)
            && $stable(frame_end) && $stable(zero_weight))
        else $error("waiting result changed");

    a_stall_released: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_ready |=> in_ready)
        else $error("input stays stalled after a result was taken");

endmodule

bind weighted_frame_blend_unit wfb_checker u_wfb_checker (.*);

`default_nettype wire
